// File: sv/lz_stream_decompressor_core_defines.svh
// assertion macros used by the checker file lzsd_checker.sv
// no dependencies; included by bare file name
`ifndef LZ_STREAM_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ_STREAM_DECOMPRESSOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LZSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzsd check failed");

// next-cycle implication, disabled while in reset
`define LZSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzsd check failed");

`endif

// File: sv/lzsd_pkg.sv
// shared types, constants and helpers of the lz stream decompressor
// no dependencies
package lzsd_pkg;

    localparam int unsigned HIST_AW = 16;
    localparam int unsigned WINDOW  = 1 << HIST_AW;

    localparam logic [31:0] MAGIC       = 32'h57BC0000;
    localparam logic [7:0]  END_TOK0    = 8'h05;
    localparam logic [7:0]  END_TOK1    = 8'hFA;
    localparam logic [16:0] SUM_MODULUS = 17'd65521;

    localparam logic [3:0] ST_RUNNING    = 4'd0;
    localparam logic [3:0] ST_DONE_OK    = 4'd1;
    localparam logic [3:0] ST_BAD_MAGIC  = 4'd2;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd3;
    localparam logic [3:0] ST_OVERRUN    = 4'd4;
    localparam logic [3:0] ST_BEFORE     = 4'd5;
    localparam logic [3:0] ST_BEYOND     = 4'd6;
    localparam logic [3:0] ST_BAD_TOKEN  = 4'd7;
    localparam logic [3:0] ST_LEN_MISM   = 4'd8;
    localparam logic [3:0] ST_SUM_MISM   = 4'd9;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_LITERAL,
        PH_CHECKSUM,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        TK_LIT,
        TK_COPY,
        TK_END
    } tok_kind_t;

    // one queued input word
    typedef struct packed {
        logic       drain;
        logic [7:0] data;
    } item_t;

    // decoded step handed from the decoder to the emit stage
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic               copy;
        logic [7:0]         lit;
        logic [HIST_AW-1:0] raddr;
        logic [HIST_AW-1:0] waddr;
        logic               accepted;
        logic               pending;
        logic [3:0]         status;
    } step_t;

    // token length in bytes from its first byte, zero for undefined codes
    function automatic logic [2:0] tok_len(input logic [7:0] b0);
        logic [2:0] n;
        if (b0 >= 8'h80)      n = 3'd2;
        else if (b0 >= 8'h40) n = 3'd3;
        else if (b0 >= 8'h20) n = 3'd1;
        else if (b0 >= 8'h18) n = 3'd4;
        else if (b0 >= 8'h10) n = 3'd5;
        else if (b0 >= 8'h08) n = 3'd2;
        else if (b0 == 8'h07) n = 3'd3;
        else if (b0 == 8'h06) n = 3'd5;
        else if (b0 == 8'h05) n = 3'd2;
        else if (b0 == 8'h04) n = 3'd6;
        else                  n = 3'd0;
        return n;
    endfunction

endpackage

// File: sv/lz_stream_decompressor_core.sv
// LZ stream decompressor with adler-32 check. Each input word is either a compressed
// byte (tuser 0) or a drain request for the next back-reference byte (tuser 1); every
// input word gives exactly one output word. While the output is not stalled, the block
// sustains one word per clock: a four-word input queue feeds the decoder, which handles
// one word per cycle, and the emit stage does one write and one registered read of the
// 64 KiB history memory per cycle, forwarding the byte just written so that overlapping
// copies need no bubble. From the queue head, each word is registered in the emit stage
// and then in the output register; a stalled output holds the decoder and the emit stage.
// Stream bytes offered while a copy is pending are answered with accepted low and must
// be offered again after draining.
// top level; depends on lzsd_pkg, lzsd_front, lzsd_exec and lzsd_emit
module lz_stream_decompressor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, accepted, copy_pending, status, pad
    output logic [0:0]  m_axis_tuser    // byte_valid
);
    import lzsd_pkg::*;

    item_t       head;
    step_t       step;
    logic        head_valid;
    logic        pop;
    logic        adv;
    logic [31:0] adler;

    lzsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head_valid    (head_valid),
        .head          (head)
    );

    lzsd_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .head_valid (head_valid),
        .head       (head),
        .adler      (adler),
        .pop        (pop),
        .step       (step)
    );

    lzsd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .adv           (adv),
        .adler         (adler),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: sv/lzsd_front.sv
// input queue: takes stream words and classifies them as stream bytes or drains
// depends on lzsd_pkg
module lzsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // in_byte
    input  logic [0:0]    s_axis_tuser,   // req_type
    input  logic          pop,
    output logic          head_valid,
    output lzsd_pkg::item_t head
);
    import lzsd_pkg::*;

    item_t      q_reg [4];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push, do_pop;

    assign s_axis_tready = (cnt_reg != 3'd4);
    assign head_valid    = (cnt_reg != 3'd0);
    assign head          = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && head_valid;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        wr_ptr_next = wr_ptr_reg + 2'(push);
        cnt_next    = cnt_reg + 3'(push) - 3'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].drain <= s_axis_tuser[0];
            q_reg[wr_ptr_reg].data  <= s_axis_tdata;
        end
    end

endmodule

// File: sv/lzsd_exec.sv
// decoder: header check, token parsing, copy bookkeeping and error state
// depends on lzsd_pkg; adler sums come back from lzsd_emit
module lzsd_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            head_valid,
    input  lzsd_pkg::item_t head,
    input  logic [31:0]     adler,
    output logic            pop,
    output lzsd_pkg::step_t step
);
    import lzsd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [3:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]        exp_len_reg, exp_len_next;
    logic [31:0]        prod_reg, prod_next;
    logic [7:0]         tb_reg [6];
    logic [7:0]         tb_next [6];
    logic [2:0]         tok_cnt_reg, tok_cnt_next;
    logic [16:0]        lit_left_reg, lit_left_next;
    logic [16:0]        copy_left_reg, copy_left_next;
    logic [HIST_AW-1:0] dist_reg, dist_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [3:0]         err_reg, err_next;

    logic [7:0]  cur [6];
    logic [7:0]  b;
    logic        fire, live, emit, is_copy, acc;
    logic [2:0]  n;
    tok_kind_t   kind;
    logic [24:0] dist_sel;
    logic [16:0] len_sel;
    logic [7:0]  magic_byte;

    assign fire = adv && head_valid;
    assign pop  = fire;
    assign b    = head.data;
    assign live = (phase_reg != PH_DONE) && (phase_reg != PH_ERROR);

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            cur[k] = (tok_cnt_reg == 3'(k)) ? b : tb_reg[k];
        end
    end

    always_comb
    begin
        case (hdr_cnt_reg[1:0])
            2'd0:    magic_byte = MAGIC[31:24];
            2'd1:    magic_byte = MAGIC[23:16];
            2'd2:    magic_byte = MAGIC[15:8];
            default: magic_byte = MAGIC[7:0];
        endcase
    end

    // token fields, valid once all of its bytes are in
    always_comb
    begin
        kind     = TK_END;
        dist_sel = '0;
        len_sel  = '0;
        if (cur[0] >= 8'h80)
        begin
            kind = TK_COPY;
            dist_sel = 25'(cur[1]) + 25'd1;
            len_sel  = 17'(cur[0][6:0]) + 17'd1;
        end
        else if (cur[0] >= 8'h40)
        begin
            kind = TK_COPY;
            dist_sel = 25'({cur[0][5:0], cur[1]}) + 25'd1;
            len_sel  = 17'(cur[2]) + 17'd1;
        end
        else if (cur[0] >= 8'h20)
        begin
            kind = TK_LIT;
            len_sel = 17'(cur[0][4:0]) + 17'd1;
        end
        else if (cur[0] >= 8'h18)
        begin
            kind = TK_COPY;
            dist_sel = 25'({cur[0][2:0], cur[1], cur[2]}) + 25'd1;
            len_sel  = 17'(cur[3]) + 17'd1;
        end
        else if (cur[0] >= 8'h10)
        begin
            kind = TK_COPY;
            dist_sel = 25'({cur[0][3:0], cur[1], cur[2]}) + 25'd1;
            len_sel  = 17'({cur[3], cur[4]}) + 17'd1;
        end
        else if (cur[0] >= 8'h08)
        begin
            kind = TK_LIT;
            len_sel = 17'({cur[0][2:0], cur[1]}) + 17'd1;
        end
        else if (cur[0] == 8'h07)
        begin
            kind = TK_LIT;
            len_sel = 17'({cur[1], cur[2]}) + 17'd1;
        end
        else if (cur[0] == 8'h06)
        begin
            kind = TK_COPY;
            dist_sel = 25'({cur[1], cur[2], cur[3]}) + 25'd1;
            len_sel  = 17'(cur[4]) + 17'd1;
        end
        else if (cur[0] == 8'h04)
        begin
            kind = TK_COPY;
            dist_sel = 25'({cur[1], cur[2], cur[3]}) + 25'd1;
            len_sel  = 17'({cur[4], cur[5]}) + 17'd1;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        exp_len_next   = exp_len_reg;
        prod_next      = prod_reg;
        tok_cnt_next   = tok_cnt_reg;
        lit_left_next  = lit_left_reg;
        copy_left_next = copy_left_reg;
        dist_next      = dist_reg;
        wp_next        = wp_reg;
        err_next       = err_reg;
        for (int k = 0; k < 6; k++)
        begin
            tb_next[k] = tb_reg[k];
        end
        emit    = 1'b0;
        is_copy = 1'b0;
        acc     = 1'b0;
        n       = tok_len(cur[0]);

        if (fire && !head.drain && live && copy_left_reg == '0)
        begin
            acc = 1'b1;
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg < 4'd4 && b != magic_byte)
                    begin
                        err_next = ST_BAD_MAGIC;
                        phase_next = PH_ERROR;
                    end
                    else if (hdr_cnt_reg >= 4'd4 && hdr_cnt_reg < 4'd8 && b != 8'd0)
                    begin
                        err_next = ST_TOO_LARGE;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (hdr_cnt_reg >= 4'd8 && hdr_cnt_reg < 4'd12)
                        begin
                            exp_len_next = {exp_len_reg[23:0], b};
                        end
                        if (hdr_cnt_reg == 4'd15)
                        begin
                            phase_next = PH_TOKEN;
                            hdr_cnt_next = '0;
                        end
                        else
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        end
                    end
                end
                PH_LITERAL:
                begin
                    emit = 1'b1;
                    lit_left_next = lit_left_reg - 17'd1;
                    if (lit_left_reg == 17'd1)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    tb_next[tok_cnt_reg] = b;
                    tok_cnt_next = tok_cnt_reg + 3'd1;
                    if (n == 3'd0)
                    begin
                        err_next = ST_BAD_TOKEN;
                        phase_next = PH_ERROR;
                    end
                    else if (tok_cnt_reg + 3'd1 >= n)
                    begin
                        tok_cnt_next = '0;
                        if (kind == TK_END)
                        begin
                            if (cur[1] != END_TOK1)
                            begin
                                err_next = ST_BAD_TOKEN;
                                phase_next = PH_ERROR;
                            end
                            else if (prod_reg != exp_len_reg)
                            begin
                                err_next = ST_LEN_MISM;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_CHECKSUM;
                            end
                        end
                        else if ({1'b0, prod_reg} + 33'(len_sel) > {1'b0, exp_len_reg})
                        begin
                            err_next = ST_OVERRUN;
                            phase_next = PH_ERROR;
                        end
                        else if (kind == TK_LIT)
                        begin
                            lit_left_next = len_sel;
                            phase_next = PH_LITERAL;
                        end
                        else if (32'(dist_sel) > prod_reg)
                        begin
                            err_next = ST_BEFORE;
                            phase_next = PH_ERROR;
                        end
                        else if (dist_sel > 25'(WINDOW))
                        begin
                            err_next = ST_BEYOND;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            copy_left_next = len_sel;
                            dist_next = dist_sel[HIST_AW-1:0];
                        end
                    end
                end
                PH_CHECKSUM:
                begin
                    tb_next[tok_cnt_reg] = b;
                    tok_cnt_next = tok_cnt_reg + 3'd1;
                    if (tok_cnt_reg == 3'd3)
                    begin
                        tok_cnt_next = '0;
                        if ({cur[0], cur[1], cur[2], cur[3]} == adler)
                        begin
                            err_next = ST_DONE_OK;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            err_next = ST_SUM_MISM;
                            phase_next = PH_ERROR;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (phase_next == PH_ERROR)
            begin
                lit_left_next = '0;
                copy_left_next = '0;
            end
        end
        else if (fire && head.drain && live && copy_left_reg != '0)
        begin
            emit = 1'b1;
            is_copy = 1'b1;
            copy_left_next = copy_left_reg - 17'd1;
        end

        if (emit)
        begin
            wp_next = wp_reg + HIST_AW'(1);
            prod_next = prod_reg + 32'd1;
        end
    end

    always_comb
    begin
        step.valid    = fire;
        step.wr       = emit;
        step.copy     = is_copy;
        step.lit      = b;
        step.raddr    = wp_reg - dist_reg;
        step.waddr    = wp_reg;
        step.accepted = acc;
        step.pending  = (copy_left_next != '0);
        step.status   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            exp_len_reg   <= '0;
            prod_reg      <= '0;
            tok_cnt_reg   <= '0;
            lit_left_reg  <= '0;
            copy_left_reg <= '0;
            dist_reg      <= '0;
            wp_reg        <= '0;
            err_reg       <= ST_RUNNING;
            for (int k = 0; k < 6; k++)
            begin
                tb_reg[k] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            exp_len_reg   <= exp_len_next;
            prod_reg      <= prod_next;
            tok_cnt_reg   <= tok_cnt_next;
            lit_left_reg  <= lit_left_next;
            copy_left_reg <= copy_left_next;
            dist_reg      <= dist_next;
            wp_reg        <= wp_next;
            err_reg       <= err_next;
            for (int k = 0; k < 6; k++)
            begin
                tb_reg[k] <= tb_next[k];
            end
        end
    end

endmodule

// File: sv/lzsd_emit.sv
// emit stage: history memory with forwarding, adler-32 sums and output register
// depends on lzsd_pkg; fed by lzsd_exec
module lzsd_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  lzsd_pkg::step_t step,
    output logic            adv,
    output logic [31:0]     adler,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // out_byte, accepted, copy_pending, status
    output logic [0:0]      m_axis_tuser    // byte_valid
);
    import lzsd_pkg::*;

    logic [7:0]  hist_mem [WINDOW];
    logic [7:0]  rdata_reg;
    step_t       b_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;
    logic [15:0] sum_lo_reg, sum_lo_next;
    logic [15:0] sum_hi_reg, sum_hi_next;
    logic        ovalid_reg;
    logic [15:0] odata_reg, odata_next;
    logic        obv_reg;
    logic [7:0]  b_byte;
    logic [16:0] lo_sum, hi_sum;
    logic        b_wr;

    assign adv           = !ovalid_reg || m_axis_tready;
    assign adler         = {sum_hi_reg, sum_lo_reg};
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = obv_reg;
    assign b_wr          = b_reg.valid && b_reg.wr;

    // a copy one byte back reads what the previous word is writing right now
    assign b_byte = !b_reg.copy ? b_reg.lit : (fwd_reg ? fwd_data_reg : rdata_reg);

    always_comb
    begin
        lo_sum = 17'(sum_lo_reg) + 17'(b_byte);
        if (lo_sum >= SUM_MODULUS)
        begin
            lo_sum = lo_sum - SUM_MODULUS;
        end
        hi_sum = 17'(sum_hi_reg) + lo_sum;
        if (hi_sum >= SUM_MODULUS)
        begin
            hi_sum = hi_sum - SUM_MODULUS;
        end
        sum_lo_next = b_wr ? lo_sum[15:0] : sum_lo_reg;
        sum_hi_next = b_wr ? hi_sum[15:0] : sum_hi_reg;
        odata_next  = {2'b00, b_reg.status, b_reg.pending, b_reg.accepted,
                       b_reg.wr ? b_byte : 8'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_wr)
            begin
                hist_mem[b_reg.waddr] <= b_byte;
            end
            rdata_reg <= hist_mem[step.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_data_reg <= b_byte;
            odata_reg    <= odata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg       <= '0;
            fwd_reg     <= 1'b0;
            sum_lo_reg  <= 16'd1;
            sum_hi_reg  <= '0;
            ovalid_reg  <= 1'b0;
            obv_reg     <= 1'b0;
        end
        else if (adv)
        begin
            b_reg       <= step;
            fwd_reg     <= b_wr && (step.raddr == b_reg.waddr);
            sum_lo_reg  <= sum_lo_next;
            sum_hi_reg  <= sum_hi_next;
            ovalid_reg  <= b_reg.valid;
            obv_reg     <= b_reg.wr;
        end
    end

endmodule

// File: sv/lzsd_checker.sv
// port-level checks on the decompressor output, bound to the top level
// depends on lzsd_pkg and lz_stream_decompressor_core_defines.svh
`include "lz_stream_decompressor_core_defines.svh"

module lzsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    import lzsd_pkg::*;

    logic        byte_valid;
    logic        pending;
    logic        held;
    logic [3:0]  status;
    logic [16:0] out_word;

    assign byte_valid = m_axis_tuser[0];
    assign pending    = m_axis_tdata[9];
    assign held       = m_axis_tvalid && !m_axis_tready;
    assign status     = m_axis_tdata[13:10];
    assign out_word   = {m_axis_tuser, m_axis_tdata};

    // a byte only comes out while the stream is still running
    `LZSD_ASSERT_NOW(a_byte_running, clk, rst_n, m_axis_tvalid && byte_valid, status == ST_RUNNING)
    // a pending copy means no error or end has been seen
    `LZSD_ASSERT_NOW(a_pending_running, clk, rst_n, m_axis_tvalid && pending, status == ST_RUNNING)
    // a missing byte reads as zero
    `LZSD_ASSERT_NOW(a_idle_byte_zero, clk, rst_n, m_axis_tvalid && !byte_valid, m_axis_tdata[7:0] == 8'd0)
    // stalled word holds
    `LZSD_ASSERT_NEXT(a_hold, clk, rst_n, held, m_axis_tvalid && $stable(out_word))

endmodule

bind lz_stream_decompressor_core lzsd_checker u_lzsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/testbench.sv
// self-checking testbench for lz_stream_decompressor_core: one compressed stream,
// checked word by word against a behavioural predictor of the decoder
// depends on lzsd_pkg and the core rtl
module testbench;
    import lzsd_pkg::*;

    localparam int unsigned OUT_LEN = 300;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       accepted;
        logic       copy_pending;
        logic [3:0] status;
    } result_t;

    typedef struct packed {
        logic    drain;
        logic [7:0] data;
        logic    typed;
        result_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // side-band carried with the word on offer
    logic        cur_typed;
    result_t     cur_want;
    logic        quiet;
    logic        failed;
    result_t     expected_q[$];
    row_t        dir_rows[$];
    int unsigned made;

    // decoder state
    phase_t      dec_phase;
    logic [3:0]  hdr_cnt;
    logic [31:0] want_len;
    logic [31:0] out_cnt;
    logic [7:0]  tok[0:5];
    int unsigned tok_cnt;
    logic [31:0] lit_left;
    logic [31:0] cp_left;
    logic [31:0] cp_dist;
    logic [7:0]  hist_mem[0:65535];
    logic [15:0] wr_ptr;
    logic [31:0] adler_lo;
    logic [31:0] adler_hi;
    logic [3:0]  err_code;

    lz_stream_decompressor_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned token_size(input logic [7:0] b0);
        if (b0 >= 8'h80) return 2;
        if (b0 >= 8'h40) return 3;
        if (b0 >= 8'h20) return 1;
        if (b0 >= 8'h18) return 4;
        if (b0 >= 8'h10) return 5;
        if (b0 >= 8'h08) return 2;
        if (b0 == 8'h07) return 3;
        if (b0 == 8'h06) return 5;
        if (b0 == 8'h05) return 2;
        if (b0 == 8'h04) return 6;
        return 0;
    endfunction

    task automatic dec_fail(input logic [3:0] code);
        err_code  = code;
        dec_phase = PH_ERROR;
        cp_left   = 0;
        lit_left  = 0;
    endtask

    task automatic hist_write(input logic [7:0] v);
        hist_mem[wr_ptr] = v;
        wr_ptr   = wr_ptr + 16'd1;
        adler_lo = (adler_lo + v) % SUM_MODULUS;
        adler_hi = (adler_hi + adler_lo) % SUM_MODULUS;
        out_cnt  = out_cnt + 1;
    endtask

    task automatic open_literal(input logic [31:0] len);
        if (longint'(out_cnt) + len > longint'(want_len))
        begin
            dec_fail(ST_OVERRUN);
            return;
        end
        lit_left  = len;
        dec_phase = PH_LITERAL;
    endtask

    task automatic open_copy(input logic [31:0] back, input logic [31:0] len);
        if (longint'(out_cnt) + len > longint'(want_len))
        begin
            dec_fail(ST_OVERRUN);
            return;
        end
        if (back > out_cnt)
        begin
            dec_fail(ST_BEFORE);
            return;
        end
        if (back > WINDOW)
        begin
            dec_fail(ST_BEYOND);
            return;
        end
        cp_left = len;
        cp_dist = back;
    endtask

    task automatic close_token();
        logic [31:0] b0, b1, b2, b3, b4, b5;
        b0 = tok[0]; b1 = tok[1]; b2 = tok[2];
        b3 = tok[3]; b4 = tok[4]; b5 = tok[5];
        tok_cnt = 0;
        if (b0 >= 'h80)
            open_copy(b1 + 1, b0 - 'h80 + 1);
        else if (b0 >= 'h40)
            open_copy(((b0 << 8) | b1) - 'h4000 + 1, b2 + 1);
        else if (b0 >= 'h20)
            open_literal(b0 - 'h20 + 1);
        else if (b0 >= 'h18)
            open_copy(((b0 << 16) | (b1 << 8) | b2) - 'h180000 + 1, b3 + 1);
        else if (b0 >= 'h10)
            open_copy(((b0 << 16) | (b1 << 8) | b2) - 'h100000 + 1, ((b3 << 8) | b4) + 1);
        else if (b0 >= 'h08)
            open_literal(((b0 << 8) | b1) - 'h0800 + 1);
        else if (b0 == 'h07)
            open_literal(((b1 << 8) | b2) + 1);
        else if (b0 == 'h06)
            open_copy(((b1 << 16) | (b2 << 8) | b3) + 1, b4 + 1);
        else if (b0 == 'h04)
            open_copy(((b1 << 16) | (b2 << 8) | b3) + 1, ((b4 << 8) | b5) + 1);
        else if (b1 != END_TOK1)
            dec_fail(ST_BAD_TOKEN);
        else if (out_cnt != want_len)
            dec_fail(ST_LEN_MISM);
        else
            dec_phase = PH_CHECKSUM;
    endtask

    task automatic take_stream_byte(input logic [7:0] b, inout result_t r);
        logic [31:0] sum_word;
        case (dec_phase)
            PH_HEADER:
            begin
                if (hdr_cnt < 4)
                begin
                    if (b != 8'(MAGIC >> (8 * (3 - hdr_cnt))))
                    begin
                        dec_fail(ST_BAD_MAGIC);
                        return;
                    end
                end
                else if (hdr_cnt < 8)
                begin
                    if (b != 8'd0)
                    begin
                        dec_fail(ST_TOO_LARGE);
                        return;
                    end
                end
                else if (hdr_cnt < 12)
                    want_len = {want_len[23:0], b};
                if (hdr_cnt == 4'd15)
                begin
                    dec_phase = PH_TOKEN;
                    hdr_cnt   = '0;
                end
                else
                    hdr_cnt = hdr_cnt + 4'd1;
            end
            PH_LITERAL:
            begin
                hist_write(b);
                r.byte_valid = 1'b1;
                r.out_byte   = b;
                lit_left     = lit_left - 1;
                if (lit_left == 0)
                    dec_phase = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                tok[tok_cnt] = b;
                tok_cnt      = tok_cnt + 1;
                if (token_size(tok[0]) == 0)
                    dec_fail(ST_BAD_TOKEN);
                else if (tok_cnt >= token_size(tok[0]))
                    close_token();
            end
            PH_CHECKSUM:
            begin
                tok[tok_cnt] = b;
                tok_cnt      = tok_cnt + 1;
                if (tok_cnt >= 4)
                begin
                    sum_word = {tok[0], tok[1], tok[2], tok[3]};
                    tok_cnt  = 0;
                    if (sum_word == {adler_hi[15:0], adler_lo[15:0]})
                    begin
                        err_code  = ST_DONE_OK;
                        dec_phase = PH_DONE;
                    end
                    else
                        dec_fail(ST_SUM_MISM);
                end
            end
            default: ;
        endcase
    endtask

    // expected output word for one accepted input word
    task automatic predict_word(input logic drain, input logic [7:0] b, output result_t r);
        logic live;
        logic [7:0] v;
        r    = '0;
        live = dec_phase != PH_DONE && dec_phase != PH_ERROR;
        if (!drain)
        begin
            if (live && cp_left == 0)
            begin
                r.accepted = 1'b1;
                take_stream_byte(b, r);
            end
        end
        else if (live && cp_left != 0)
        begin
            v = hist_mem[wr_ptr - cp_dist[15:0]];
            r.byte_valid = 1'b1;
            r.out_byte   = v;
            hist_write(v);
            cp_left = cp_left - 1;
        end
        r.copy_pending = cp_left != 0;
        r.status       = err_code;
    endtask

    always @(posedge clk)
    begin
        result_t r;
        result_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_word(s_axis_tuser[0], s_axis_tdata, r);
            expected_q.push_back(cur_typed ? cur_want : r);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9],
                   m_axis_tdata[13:10]};
            if (expected_q.size() == 0)
            begin
                $error("output word with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                r = expected_q.pop_front();
                if (got.byte_valid !== r.byte_valid)
                begin
                    $error("byte_valid: expected %0d, got %0d", r.byte_valid, got.byte_valid);
                    failed = 1'b1;
                end
                if (got.out_byte !== r.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", r.out_byte, got.out_byte);
                    failed = 1'b1;
                end
                if (got.accepted !== r.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", r.accepted, got.accepted);
                    failed = 1'b1;
                end
                if (got.copy_pending !== r.copy_pending)
                begin
                    $error("copy_pending: expected %0d, got %0d", r.copy_pending,
                           got.copy_pending);
                    failed = 1'b1;
                end
                if (got.status !== r.status)
                begin
                    $error("status: expected %0d, got %0d", r.status, got.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int unsigned stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                m_axis_tready = 1'b1;
            else if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                stall = stall - 1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                stall = $urandom_range(0, 6);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send_row(input row_t w);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = w.drain;
        s_axis_tdata  = w.data;
        cur_typed     = w.typed;
        cur_want      = w.want;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row({1'b0, b, 1'b0, result_t'('0)});
    endtask

    task automatic send_drain();
        send_row({1'b1, 8'h00, 1'b0, result_t'('0)});
    endtask

    function automatic int unsigned pick_len(input int unsigned cap);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(1, cap);
        return $urandom_range(1, cap < 8 ? cap : 8);
    endfunction

    task automatic add_row(input logic drain, input logic [7:0] b, input logic typed,
                           input result_t want);
        dir_rows.push_back({drain, b, typed, want});
    endtask

    task automatic random_literal(input int unsigned room);
        int unsigned form;
        int unsigned len;
        logic [15:0] v;
        form = $urandom_range(0, 2);
        len  = pick_len(form == 0 && room > 32 ? 32 : room);
        v    = 16'(len - 1);
        if (form == 0)
            send_byte(8'(len + 31));
        else if (form == 1)
        begin
            v = v + 16'h0800;
            send_byte(v[15:8]);
            send_byte(v[7:0]);
        end
        else
        begin
            send_byte(8'h07);
            send_byte(v[15:8]);
            send_byte(v[7:0]);
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            // a stray drain in mid literal does nothing
            if ($urandom_range(0, 19) == 0)
                send_drain();
            send_byte(8'($urandom_range(0, 255)));
        end
        made = made + len;
    endtask

    task automatic random_copy(input int unsigned room);
        int unsigned form;
        int unsigned len;
        int unsigned back;
        int unsigned noise_at;
        logic [23:0] d;
        logic [15:0] n;
        back = $urandom_range(1, made);
        form = back <= 256 ? $urandom_range(0, 5) : $urandom_range(1, 5);
        len  = pick_len(form == 0 ? (room > 128 ? 128 : room) :
                        form <= 3 ? (room > 256 ? 256 : room) : room);
        n    = 16'(len - 1);
        d    = 24'(back - 1);
        case (form)
            0:
            begin
                send_byte(8'h80 + n[7:0]);
                send_byte(d[7:0]);
            end
            1:
            begin
                d = d + 24'h004000;
                send_byte(d[15:8]);
                send_byte(d[7:0]);
                send_byte(n[7:0]);
            end
            2:
            begin
                d = d + 24'h180000;
                send_byte(d[23:16]);
                send_byte(d[15:8]);
                send_byte(d[7:0]);
                send_byte(n[7:0]);
            end
            3:
            begin
                send_byte(8'h06);
                send_byte(d[23:16]);
                send_byte(d[15:8]);
                send_byte(d[7:0]);
                send_byte(n[7:0]);
            end
            4:
            begin
                d = d + 24'h100000;
                send_byte(d[23:16]);
                send_byte(d[15:8]);
                send_byte(d[7:0]);
                send_byte(n[15:8]);
                send_byte(n[7:0]);
            end
            default:
            begin
                send_byte(8'h04);
                send_byte(d[23:16]);
                send_byte(d[15:8]);
                send_byte(d[7:0]);
                send_byte(n[15:8]);
                send_byte(n[7:0]);
            end
        endcase
        // a byte offered mid copy must be turned away
        noise_at = $urandom_range(0, 3) == 0 ? $urandom_range(0, len - 1) : len;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (i == noise_at)
                send_byte(8'($urandom_range(0, 255)));
            send_drain();
        end
        made = made + len;
    endtask

    initial
    begin
        result_t hdr_ok;
        result_t held;
        result_t idle;
        logic [31:0] sum_word;
        failed        = 1'b0;
        quiet         = 1'b0;
        made          = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        cur_typed     = 1'b0;
        cur_want      = '0;
        dec_phase     = PH_HEADER;
        hdr_cnt       = '0;
        want_len      = 0;
        out_cnt       = 0;
        tok_cnt       = 0;
        lit_left      = 0;
        cp_left       = 0;
        cp_dist       = 0;
        wr_ptr        = '0;
        adler_lo      = 1;
        adler_hi      = 0;
        err_code      = ST_RUNNING;
        rst_n         = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        hdr_ok = {1'b0, 8'h00, 1'b1, 1'b0, ST_RUNNING};
        held   = {1'b0, 8'h00, 1'b0, 1'b1, ST_RUNNING};
        idle   = {1'b0, 8'h00, 1'b0, 1'b0, ST_RUNNING};
        // header: magic, zero high word, length 300, four ignored bytes
        add_row(1'b0, 8'h57, 1'b1, hdr_ok);
        add_row(1'b0, 8'hBC, 1'b1, hdr_ok);
        add_row(1'b0, 8'h00, 1'b1, hdr_ok);
        add_row(1'b0, 8'h00, 1'b1, hdr_ok);
        for (int i = 0; i < 6; i++)
            add_row(1'b0, 8'h00, 1'b1, hdr_ok);
        add_row(1'b0, 8'h01, 1'b1, hdr_ok);
        add_row(1'b0, 8'h2C, 1'b1, hdr_ok);
        add_row(1'b0, 8'hFF, 1'b1, hdr_ok);
        add_row(1'b0, 8'h80, 1'b1, hdr_ok);
        add_row(1'b0, 8'h01, 1'b1, hdr_ok);
        add_row(1'b0, 8'h7E, 1'b1, hdr_ok);
        // short literal with extreme bytes
        add_row(1'b0, 8'h22, 1'b0, idle);
        add_row(1'b0, 8'h00, 1'b0, idle);
        add_row(1'b0, 8'hFF, 1'b0, idle);
        add_row(1'b0, 8'h5A, 1'b0, idle);
        // distance one, copy of one byte
        add_row(1'b0, 8'h80, 1'b0, idle);
        add_row(1'b0, 8'h00, 1'b0, idle);
        add_row(1'b1, 8'h00, 1'b0, idle);
        // copy of two from three back, a byte offered while pending, a drain with none
        add_row(1'b0, 8'h81, 1'b0, idle);
        add_row(1'b0, 8'h02, 1'b0, idle);
        add_row(1'b0, 8'hAA, 1'b1, held);
        add_row(1'b1, 8'h00, 1'b0, idle);
        add_row(1'b1, 8'h00, 1'b0, idle);
        add_row(1'b1, 8'hFF, 1'b1, idle);
        foreach (dir_rows[i])
            send_row(dir_rows[i]);
        made = 6;

        while (made < OUT_LEN)
        begin
            if (made > OUT_LEN * 3 / 4)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 4)
                random_literal(OUT_LEN - made);
            else
                random_copy(OUT_LEN - made);
        end
        send_byte(END_TOK0);
        send_byte(END_TOK1);

        // hold off until the output has caught up, then send the running sum
        s_axis_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        sum_word = {adler_hi[15:0], adler_lo[15:0]};
        send_byte(sum_word[31:24]);
        send_byte(sum_word[23:16]);
        send_byte(sum_word[15:8]);
        send_byte(sum_word[7:0]);
        // words after the end are ignored
        send_byte(8'h57);
        send_drain();
        send_byte(8'h00);
        s_axis_tvalid = 1'b0;

        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (!failed && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/lzsd_pkg.sv
sv/lzsd_front.sv
sv/lzsd_exec.sv
sv/lzsd_emit.sv
sv/lz_stream_decompressor_core.sv
sv/lzsd_checker.sv
sim/testbench.sv
